// File: design/indexed_char_list_assert.svh
// Assertion macros used by the checker file.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef INDEXED_CHAR_LIST_ASSERT_SVH
`define INDEXED_CHAR_LIST_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent
`define ICL_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("indexed_char_list assertion failed");

// Check the consequent in the cycle after the antecedent
`define ICL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("indexed_char_list assertion failed");

`endif

// File: design/icl_pkg.sv
package icl_pkg;

    // Default list capacity
    localparam int CAPACITY = 64;

    // Operation codes on the mode field
    localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
    localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
    localparam logic [3:0] MODE_INSERT     = 4'd2;
    localparam logic [3:0] MODE_POP_FRONT  = 4'd3;
    localparam logic [3:0] MODE_POP_BACK   = 4'd4;
    localparam logic [3:0] MODE_DELETE     = 4'd5;
    localparam logic [3:0] MODE_READ       = 4'd6;
    localparam logic [3:0] MODE_WRITE      = 4'd7;
    localparam logic [3:0] MODE_CLEAR      = 4'd8;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INS,
        CO_DEL,
        CO_WR,
        CO_RD
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic [7:0] value;
    } t_cell_cmd;

endpackage

// File: design/icl_cell.sv
module icl_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic              i_clk,
    input  icl_pkg::t_cell_cmd i_cmd,
    input  logic [IDX_W-1:0]  i_at,
    input  logic [7:0]        i_left,
    input  logic [7:0]        i_right,
    output logic [7:0]        o_data,
    output logic [7:0]        o_read
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [7:0] r_data;
    logic [7:0] n_data;
    logic [7:0] r_read;
    logic [7:0] n_read;

    // Pick this cell's next byte from the broadcast operation
    always_comb begin
        n_data = r_data;
        n_read = 8'h00;
        case (i_cmd.op)
            icl_pkg::CO_INS: begin
                if (MY_IDX == i_at) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX > i_at) begin
                    n_data = i_left;
                end
            end
            icl_pkg::CO_DEL: begin
                if (MY_IDX >= i_at) begin
                    n_data = i_right;
                end
            end
            icl_pkg::CO_WR: begin
                if (MY_IDX == i_at) begin
                    n_data = i_cmd.value;
                end
            end
            icl_pkg::CO_RD: begin
                if (MY_IDX == i_at) begin
                    n_read = r_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_read <= n_read;
    end

    assign o_data = r_data;
    assign o_read = r_read;

endmodule

// File: design/indexed_char_list.sv
// A result passes the cell registers and then the output register after its item is accepted.
// No new item is taken while the cell row is being gathered or a result is held stalled;
// the gather step ORs the masked read bytes of the cell row.
// Every cell compares its index with the operation index and shifts its byte.
// Reset (synchronous, active low) empties the list and drops a pending result;
// cell contents are not cleared and are read only after being written.
module indexed_char_list #(
    parameter int CAPACITY = icl_pkg::CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_mode,
    input  logic [6:0] i_position,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status,
    output logic [6:0] o_count
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = (LW > 7) ? LW : 7;

    logic [LW-1:0] r_length;
    logic [LW-1:0] n_length;
    logic          r_gather;
    logic          r_out_valid;
    logic [7:0]    r_read_data;
    logic [1:0]    r_status;
    logic [6:0]    r_count;

    logic [CW-1:0] len_c;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] at_c;
    logic          full;
    logic          empty;
    logic          accept;
    logic [1:0]    dec_status;
    icl_pkg::t_cell_cmd dec_cmd;
    icl_pkg::t_cell_cmd cell_cmd;
    logic [IW-1:0] cell_at;
    logic [7:0]    rd_or;

    logic [7:0] w_data [CAPACITY];
    logic [7:0] w_read [CAPACITY];

    assign len_c  = CW'(r_length);
    assign pos_c  = CW'(i_position);
    assign full   = (len_c >= CW'(CAPACITY));
    assign empty  = (r_length == '0);
    assign o_stall = r_gather | (r_out_valid & i_stall);
    assign accept = i_valid & ~o_stall;

    // Decode the operation against the current length
    always_comb begin
        dec_cmd.op    = icl_pkg::CO_HOLD;
        dec_cmd.value = i_value;
        at_c          = '0;
        dec_status    = icl_pkg::ST_OK;
        n_length      = r_length;
        case (i_mode)
            icl_pkg::MODE_PUSH_FRONT, icl_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    dec_status = icl_pkg::ST_FULL;
                end else begin
                    dec_cmd.op = icl_pkg::CO_INS;
                    at_c       = (i_mode == icl_pkg::MODE_PUSH_FRONT) ? '0 : len_c;
                    n_length   = r_length + 1'b1;
                end
            end
            icl_pkg::MODE_INSERT: begin
                if (pos_c > len_c) begin
                    dec_status = icl_pkg::ST_RANGE;
                end else if (full) begin
                    dec_status = icl_pkg::ST_FULL;
                end else begin
                    dec_cmd.op = icl_pkg::CO_INS;
                    at_c       = pos_c;
                    n_length   = r_length + 1'b1;
                end
            end
            icl_pkg::MODE_POP_FRONT, icl_pkg::MODE_POP_BACK: begin
                if (empty) begin
                    dec_status = icl_pkg::ST_EMPTY;
                end else begin
                    // Pop back only drops the last element
                    if (i_mode == icl_pkg::MODE_POP_FRONT) begin
                        dec_cmd.op = icl_pkg::CO_DEL;
                    end
                    n_length = r_length - 1'b1;
                end
            end
            icl_pkg::MODE_DELETE, icl_pkg::MODE_READ, icl_pkg::MODE_WRITE: begin
                if (empty) begin
                    dec_status = icl_pkg::ST_EMPTY;
                end else if (pos_c >= len_c) begin
                    dec_status = icl_pkg::ST_RANGE;
                end else begin
                    at_c = pos_c;
                    if (i_mode == icl_pkg::MODE_DELETE) begin
                        dec_cmd.op = icl_pkg::CO_DEL;
                        n_length   = r_length - 1'b1;
                    end else if (i_mode == icl_pkg::MODE_READ) begin
                        dec_cmd.op = icl_pkg::CO_RD;
                    end else begin
                        dec_cmd.op = icl_pkg::CO_WR;
                    end
                end
            end
            icl_pkg::MODE_CLEAR: begin
                n_length = '0;
            end
            default: begin
                n_length = r_length;
            end
        endcase
    end

    // Broadcast only on an accepted item
    always_comb begin
        cell_cmd = dec_cmd;
        if (!accept) begin
            cell_cmd.op = icl_pkg::CO_HOLD;
        end
    end
    assign cell_at = at_c[IW-1:0];

    // Row of cells, each linked to its neighbors
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [7:0] left_data;
        logic [7:0] right_data;
        if (k == 0) begin : g_first
            assign left_data = 8'h00;
        end else begin : g_mid_l
            assign left_data = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_data = 8'h00;
        end else begin : g_mid_r
            assign right_data = w_data[k+1];
        end
        icl_cell #(
            .IDX_W (IW),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_at    (cell_at),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (w_data[k]),
            .o_read  (w_read[k])
        );
    end

    // Gather the masked read bytes
    always_comb begin
        rd_or = 8'h00;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | w_read[k];
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length    <= '0;
            r_gather    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_gather <= accept;
            if (accept) begin
                r_length <= n_length;
            end
            if (r_gather) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= dec_status;
            r_count  <= 7'(n_length);
        end
        if (r_gather) begin
            r_read_data <= rd_or;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;
    assign o_count     = r_count;

endmodule

// File: design/icl_checker.sv
`include "indexed_char_list_assert.svh"

module icl_checker #(
    parameter int CAPACITY = icl_pkg::CAPACITY
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_read_data,
    input logic [1:0] o_status,
    input logic [6:0] o_count
);

    localparam bit         CAP_WIDE  = (CAPACITY > 127);
    localparam logic [6:0] CAP_COUNT = 7'(CAPACITY);

    // Keep a stalled result on the port
    `ICL_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)

    // Deliver a result on o_valid, past the cell and output registers, for each accepted item
    `ICL_ASSERT_NOW(a_result_time, i_valid && !o_stall, ##2 o_valid)

    // Report read data only on a successful operation
    `ICL_ASSERT_NOW(a_data_ok, o_valid && (o_read_data != 8'h00), o_status == icl_pkg::ST_OK)

    // Report an empty list with a zero count
    `ICL_ASSERT_NOW(a_empty_count, o_valid && (o_status == icl_pkg::ST_EMPTY), o_count == 7'd0)

    // Never exceed capacity
    `ICL_ASSERT_NOW(a_count_cap, o_valid, CAP_WIDE || (o_count <= CAP_COUNT))

endmodule

bind indexed_char_list icl_checker #(.CAPACITY(CAPACITY)) u_icl_checker (.*);
